// File: hw/rtl/assert_macros.svh
// Assertion helpers for the RTL files; included by tsif_dp.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: hw/rtl/tsif_pkg.sv
package tsif_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned IDX_W  = 6;
    localparam int unsigned PADDR_W = 3;

    // Byte-address register map, decoded on paddr[2].
    localparam logic REG_TARGET_SUM = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_READ,
        ST_CMP
    } tsif_state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic read_en;
        logic dec_ptr;
        logic store;
        logic set_answer;
        logic set_overflow;
        logic emit_hit;
        logic emit_miss;
        logic clear_set;
    } tsif_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic answer_given;
        logic full;
        logic empty;
        logic hit;
        logic ptr_zero;
        logic last;
    } tsif_sts_t;

endpackage

// File: hw/rtl/tsif_regs.sv
module tsif_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tsif_pkg::PADDR_W-1:0]        paddr,
    input  logic [tsif_pkg::DATA_W-1:0]         pwdata,
    output logic [tsif_pkg::DATA_W-1:0]         prdata,
    output logic                                pready,
    output logic signed [tsif_pkg::DATA_W-1:0]  target_sum
);
    import tsif_pkg::*;

    logic signed [DATA_W-1:0] target_sum_reg;
    logic signed [DATA_W-1:0] target_sum_next;
    logic                     wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        target_sum_next = target_sum_reg;
        if (wr_en && (paddr[2] == REG_TARGET_SUM))
        begin
            target_sum_next = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_sum_reg <= '0;
        end
        else
        begin
            target_sum_reg <= target_sum_next;
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_TARGET_SUM: prdata = target_sum_reg;
            default:        prdata = '0;
        endcase
    end

    assign target_sum = target_sum_reg;

endmodule

// File: hw/rtl/tsif_ctrl.sv
module tsif_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  tsif_pkg::tsif_sts_t sts,
    output tsif_pkg::tsif_cmd_t cmd
);
    import tsif_pkg::*;

    tsif_state_t state_reg;
    tsif_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (sts.answer_given || sts.full || sts.empty)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (sts.hit || sts.ptr_zero)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd  = '0;
        busy = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.capture = start;
            end
            ST_DECIDE:
            begin
                if (sts.answer_given)
                begin
                    cmd.clear_set = sts.last;
                end
                else if (sts.full)
                begin
                    cmd.set_overflow = 1'b1;
                    cmd.emit_miss    = sts.last;
                    cmd.clear_set    = sts.last;
                end
                else if (sts.empty)
                begin
                    cmd.store     = 1'b1;
                    cmd.emit_miss = sts.last;
                    cmd.clear_set = sts.last;
                end
                else
                begin
                    cmd.read_en = 1'b1;
                end
            end
            ST_READ:
            begin
                // read data is registered on entry here and compared in the compare state
            end
            ST_CMP:
            begin
                if (sts.hit)
                begin
                    cmd.emit_hit   = 1'b1;
                    cmd.set_answer = 1'b1;
                    cmd.clear_set  = sts.last;
                end
                else if (sts.ptr_zero)
                begin
                    cmd.store     = 1'b1;
                    cmd.emit_miss = sts.last;
                    cmd.clear_set = sts.last;
                end
                else
                begin
                    cmd.dec_ptr = 1'b1;
                    cmd.read_en = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: hw/rtl/tsif_dp.sv
`include "assert_macros.svh"

module tsif_dp #(
    parameter int unsigned MAX_ITEMS = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic signed [tsif_pkg::DATA_W-1:0]  value,
    input  logic                                last,
    input  logic signed [tsif_pkg::DATA_W-1:0]  target_sum,
    input  tsif_pkg::tsif_cmd_t                 cmd,
    output tsif_pkg::tsif_sts_t                 sts,
    output logic                                done,
    output logic                                found,
    output logic [tsif_pkg::IDX_W-1:0]          first_index,
    output logic [tsif_pkg::IDX_W-1:0]          second_index,
    output logic                                overflow
);
    import tsif_pkg::*;

    localparam int unsigned AW = $clog2(MAX_ITEMS);
    localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

    logic [DATA_W-1:0]        mem [MAX_ITEMS];
    logic [DATA_W-1:0]        rd_data_reg;

    logic [DATA_W-1:0]        value_reg;
    logic                     last_reg;
    logic signed [DATA_W:0]   comp_reg;
    logic signed [DATA_W:0]   comp_next;

    logic [AW-1:0]            ptr_reg;
    logic [AW-1:0]            ptr_next;
    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;
    logic [CW-1:0]            count_dec;
    logic                     answer_reg;
    logic                     answer_next;
    logic                     ovf_reg;
    logic                     ovf_next;

    logic                     done_reg;
    logic                     found_reg;
    logic [IDX_W-1:0]         first_reg;
    logic [IDX_W-1:0]         second_reg;
    logic                     ovf_out_reg;

    logic [AW+IDX_W-1:0]      ptr_ext;
    logic [CW+IDX_W-1:0]      count_ext;

    // Exact 33-bit complement; cannot wrap.
    assign comp_next = {target_sum[DATA_W-1], target_sum} - {value[DATA_W-1], value};
    assign count_dec = count_reg - CW'(1);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            value_reg <= value;
            last_reg  <= last;
            comp_reg  <= comp_next;
        end
    end

    // Value store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            mem[count_reg[AW-1:0]] <= value_reg;
        end
        if (cmd.read_en)
        begin
            rd_data_reg <= mem[ptr_next];
        end
    end

    // Scan runs from the latest stored entry downward.
    always_comb
    begin
        ptr_next = ptr_reg;
        if (cmd.capture)
        begin
            ptr_next = count_dec[AW-1:0];
        end
        else if (cmd.dec_ptr)
        begin
            ptr_next = ptr_reg - AW'(1);
        end
    end

    always_comb
    begin
        count_next  = count_reg;
        answer_next = answer_reg;
        ovf_next    = ovf_reg;
        if (cmd.store)
        begin
            count_next = count_reg + CW'(1);
        end
        if (cmd.set_answer)
        begin
            answer_next = 1'b1;
        end
        if (cmd.set_overflow)
        begin
            ovf_next = 1'b1;
        end
        if (cmd.clear_set)
        begin
            count_next  = '0;
            answer_next = 1'b0;
            ovf_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg    <= '0;
            count_reg  <= '0;
            answer_reg <= 1'b0;
            ovf_reg    <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            ptr_reg    <= ptr_next;
            count_reg  <= count_next;
            answer_reg <= answer_next;
            ovf_reg    <= ovf_next;
            done_reg   <= cmd.emit_hit || cmd.emit_miss;
        end
    end

    // Indices are reported modulo 64.
    assign ptr_ext   = {{IDX_W{1'b0}}, ptr_reg};
    assign count_ext = {{IDX_W{1'b0}}, count_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.emit_hit)
        begin
            found_reg   <= 1'b1;
            first_reg   <= ptr_ext[IDX_W-1:0];
            second_reg  <= count_ext[IDX_W-1:0];
            ovf_out_reg <= ovf_reg;
        end
        else if (cmd.emit_miss)
        begin
            found_reg   <= 1'b0;
            first_reg   <= '0;
            second_reg  <= '0;
            ovf_out_reg <= ovf_reg || cmd.set_overflow;
        end
    end

    assign sts.answer_given = answer_reg;
    assign sts.full         = (count_reg == CW'(MAX_ITEMS));
    assign sts.empty        = (count_reg == '0);
    assign sts.hit          = ({rd_data_reg[DATA_W-1], rd_data_reg} == comp_reg);
    assign sts.ptr_zero     = (ptr_reg == '0);
    assign sts.last         = last_reg;

    assign done         = done_reg;
    assign found        = found_reg;
    assign first_index  = first_reg;
    assign second_index = second_reg;
    assign overflow     = ovf_out_reg;

    `ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(MAX_ITEMS), "count past capacity")
    `ASSERT_IMPL(a_store_room, clk, rst_n, cmd.store, count_reg < CW'(MAX_ITEMS), "store when full")
    `ASSERT_IMPL(a_one_answer, clk, rst_n, cmd.emit_hit, !answer_reg, "second answer in one set")
    `ASSERT_NEXT(a_strobe_pulse, clk, rst_n, done_reg, !done_reg, "result strobe held")

endmodule

// File: hw/rtl/two_sum_index_finder_core.sv
// Channel   | Signals                                   | Direction | Handshake
// ----------+-------------------------------------------+-----------+-------------------------
// item      | start, busy, value, last                  | in        | start && !busy
// result    | done, found, first_index, second_index,   | out       | done, one cycle
//           | overflow                                  |           |
// config    | psel, penable, pwrite, paddr, pwdata,     | in/out    | APB, pready tied high
//           | prdata, pready                            |           |
//
// Sequence: an item whose set is empty, full or already answered is decided
//   without a scan; otherwise stored entries are compared latest-first, at most
//   the set size. Each compared entry passes a read state, then a compare state,
//   as the value store has a single registered read port.
// Reset: rst_n clears the set and target_sum; the value store is not cleared.
// Stalls: busy is high while a transaction is in flight; the result strobe is
//   never held off.
module two_sum_index_finder_core #(
    parameter int unsigned MAX_ITEMS = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // item transaction
    input  logic                                start,
    output logic                                busy,
    input  logic signed [tsif_pkg::DATA_W-1:0]  value,
    input  logic                                last,
    // result transaction
    output logic                                done,
    output logic                                found,
    output logic [tsif_pkg::IDX_W-1:0]          first_index,
    output logic [tsif_pkg::IDX_W-1:0]          second_index,
    output logic                                overflow,
    // register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tsif_pkg::PADDR_W-1:0]        paddr,
    input  logic [tsif_pkg::DATA_W-1:0]         pwdata,
    output logic [tsif_pkg::DATA_W-1:0]         prdata,
    output logic                                pready
);
    import tsif_pkg::*;

    tsif_cmd_t                cmd;
    tsif_sts_t                sts;
    logic signed [DATA_W-1:0] target_sum;

    // target_sum register; must only be written while idle, which the block does not enforce
    tsif_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .target_sum (target_sum)
    );

    // Sequencer: decide, then scan stored entries latest-first
    tsif_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    // Value store, complement compare, set bookkeeping, result registers
    tsif_dp #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .value        (value),
        .last         (last),
        .target_sum   (target_sum),
        .cmd          (cmd),
        .sts          (sts),
        .done         (done),
        .found        (found),
        .first_index  (first_index),
        .second_index (second_index),
        .overflow     (overflow)
    );

endmodule

// File: test/two_sum_index_finder_core_tb.sv
`timescale 1ns / 100ps

module two_sum_index_finder_core_tb;

    import tsif_pkg::*;

    localparam int unsigned MAX_ITEMS = 64;
    // Long enough to cover one full search of the value store.
    localparam int unsigned DRAIN_CYCLES = 2 * MAX_ITEMS + 16;
    // Items per random phase; twelve phases give roughly a thousand items.
    localparam int unsigned PHASE_ITEMS = 84;

    localparam logic [PADDR_W-1:0] ADDR_TARGET = {REG_TARGET_SUM, 2'b00};
    // Next word up decodes to no register; writes there must be dropped.
    localparam logic [PADDR_W-1:0] ADDR_SPARE  = {~REG_TARGET_SUM, 2'b00};

    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    typedef logic signed [DATA_W-1:0] word_t;

    typedef struct {
        bit             found;
        bit [IDX_W-1:0] first;
        bit [IDX_W-1:0] second;
        bit             ovf;
    } pair_result_t;

    // Tracks the current set the same way the block should, and keeps the
    // results still owed by the block in arrival order.
    class pair_tracker;
        word_t          target;
        word_t          kept [MAX_ITEMS];
        int unsigned    kept_cnt;
        bit             answered;
        bit             dropped;
        pair_result_t   owed [$];
        int unsigned    errors;

        function new();
            target   = '0;
            kept_cnt = 0;
            answered = 1'b0;
            dropped  = 1'b0;
            errors   = 0;
        endfunction

        task report_mismatch(input string msg);
            errors++;
            $display("[%0t] MISMATCH: %s", $time, msg);
        endtask

        // Called once per accepted item transaction.
        function void note_item(input word_t v, input bit is_last);
            logic [DATA_W:0] comp;
            bit              hit;
            int unsigned     where;
            pair_result_t    r;
            hit   = 1'b0;
            where = 0;
            if (!answered) begin
                if (kept_cnt >= MAX_ITEMS) begin
                    dropped = 1'b1;
                end
                else begin
                    // 33-bit difference: a complement outside 32 bits never matches
                    comp = {target[DATA_W-1], target} - {v[DATA_W-1], v};
                    for (int unsigned j = 0; j < kept_cnt; j++)
                        if ({kept[j][DATA_W-1], kept[j]} == comp) begin
                            hit   = 1'b1;
                            where = j;
                        end
                    if (hit) begin
                        r.found  = 1'b1;
                        r.first  = where[IDX_W-1:0];
                        r.second = kept_cnt[IDX_W-1:0];
                        r.ovf    = dropped;
                        owed.push_back(r);
                        answered = 1'b1;
                    end
                    else begin
                        kept[kept_cnt] = v;
                        kept_cnt++;
                    end
                end
            end
            if (is_last) begin
                if (!answered) begin
                    r.found  = 1'b0;
                    r.first  = '0;
                    r.second = '0;
                    r.ovf    = dropped;
                    owed.push_back(r);
                end
                kept_cnt = 0;
                answered = 1'b0;
                dropped  = 1'b0;
            end
        endfunction

        task check_result(input bit f, input bit [IDX_W-1:0] a, input bit [IDX_W-1:0] b,
                          input bit o);
            pair_result_t x;
            if (owed.size() == 0) begin
                report_mismatch($sformatf("unexpected result found=%0b first=%0d second=%0d ovf=%0b",
                                          f, a, b, o));
            end
            else begin
                x = owed.pop_front();
                if (f !== x.found || a !== x.first || b !== x.second || o !== x.ovf)
                    report_mismatch($sformatf(
                        "got found=%0b first=%0d second=%0d ovf=%0b, want %0b/%0d/%0d/%0b",
                        f, a, b, o, x.found, x.first, x.second, x.ovf));
            end
        endtask
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic signed [DATA_W-1:0] value;
    logic                   last;
    logic                   done;
    logic                   found;
    logic [IDX_W-1:0]       first_index;
    logic [IDX_W-1:0]       second_index;
    logic                   overflow;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [PADDR_W-1:0]     paddr;
    logic [DATA_W-1:0]      pwdata;
    logic [DATA_W-1:0]      prdata;
    logic                   pready;

    pair_tracker    tracker;
    int unsigned    idle_pct;       // chance in percent of an idle cycle before an item
    int unsigned    items_sent;

    two_sum_index_finder_core #(
        .MAX_ITEMS   (MAX_ITEMS)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .value        (value),
        .last         (last),
        .done         (done),
        .found        (found),
        .first_index  (first_index),
        .second_index (second_index),
        .overflow     (overflow),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop in case the block hangs on a handshake.
    initial
    begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // The result strobe cannot be held off, so every cycle with done high
    // is a result transaction; sample it at the edge that closes the cycle.
    always @(posedge clk)
    begin
        if (rst_n && done)
            tracker.check_result(found, first_index, second_index, overflow);
    end

    // APB write: setup phase, then access phase until pready, then back to idle.
    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read(input logic [PADDR_W-1:0] addr, output logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic verify_target();
        logic [DATA_W-1:0] rd;
        apb_read(ADDR_TARGET, rd);
        if (rd !== tracker.target)
            tracker.report_mismatch($sformatf("target_sum reads %h, want %h", rd, tracker.target));
    endtask

    task automatic set_target(input word_t t);
        apb_write(ADDR_TARGET, t);
        tracker.target = t;
        verify_target();
    endtask

    // One item transaction. start stays high between back-to-back items and is
    // only lowered when an idle gap is drawn.
    task automatic send_item(input word_t v, input bit is_last);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        value <= v;
        last  <= is_last;
        do @(posedge clk); while (busy);
        tracker.note_item(v, is_last);
        items_sent++;
    endtask

    // Let every owed result arrive, then give an ignored trailing item time
    // to finish before the register port is touched.
    task automatic settle();
        start <= 1'b0;
        while (tracker.owed.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Mostly values likely to collide: small numbers, complements and
    // repeats of earlier members, plus full-range and edge values.
    function automatic word_t pick_value(input word_t prior[$], input word_t tgt);
        word_t pick;
        case ($urandom_range(9))
            0, 1, 2: pick = $signed($urandom_range(16)) - 8;
            3, 4:    pick = $urandom;
            5: begin
                case ($urandom_range(3))
                    0:       pick = VAL_MIN;
                    1:       pick = VAL_MAX;
                    2:       pick = '0;
                    default: pick = -1;
                endcase
            end
            6, 7, 8: pick = (prior.size() != 0) ?
                            tgt - prior[$urandom_range(prior.size() - 1)] : word_t'($urandom);
            default: pick = (prior.size() != 0) ?
                            prior[$urandom_range(prior.size() - 1)] : word_t'($urandom);
        endcase
        return pick;
    endfunction

    // A big set of full-range values runs from four below capacity to eight past it;
    // half the time its last member completes a pair with the first one, which only
    // counts if it was stored.
    task automatic run_set(input int unsigned n, input bit big);
        word_t sent [$];
        word_t v;
        for (int unsigned i = 0; i < n; i++) begin
            if (big)
                v = (i == n - 1 && $urandom_range(1)) ? tracker.target - sent[0]
                                                      : word_t'($urandom);
            else
                v = pick_value(sent, tracker.target);
            sent.push_back(v);
            send_item(v, i == n - 1);
        end
    endtask

    initial
    begin
        int unsigned phase_start;
        int unsigned set_no;

        tracker    = new();
        items_sent = 0;
        idle_pct   = 34;

        rst_n   <= 1'b0;
        start   <= 1'b0;
        value   <= '0;
        last    <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // target_sum must come out of reset at zero
        verify_target();

        // Directed sets
        set_target(10);
        send_item(3, 1'b0);             // pair found on the last item
        send_item(7, 1'b1);
        send_item(2, 1'b0);             // duplicates: latest earlier index wins
        send_item(2, 1'b0);
        send_item(8, 1'b0);
        send_item(1, 1'b1);             // ignored after the answer, just clears
        send_item(1, 1'b1);             // single item, not found
        send_item(5, 1'b0);
        send_item(5, 1'b0);
        send_item(9, 1'b1);
        settle();

        set_target(0);
        send_item(VAL_MIN, 1'b0);       // complement is +2^31, out of range
        send_item(VAL_MIN, 1'b1);
        send_item(VAL_MAX, 1'b0);
        send_item(-VAL_MAX, 1'b0);
        send_item(0, 1'b1);
        send_item(0, 1'b0);
        send_item(0, 1'b1);
        settle();

        set_target(VAL_MIN);
        send_item(VAL_MIN, 1'b0);
        send_item(0, 1'b1);
        settle();

        set_target(VAL_MAX);
        send_item(-1, 1'b0);            // complement 2^31 cannot match
        send_item(0, 1'b0);
        send_item(VAL_MAX, 1'b1);
        settle();

        // Random phases: idle at 34%, then 87%, then back to back; four targets each
        for (int unsigned mode = 0; mode < 3; mode++) begin
            idle_pct = (mode == 0) ? 34 : (mode == 1) ? 87 : 0;
            for (int unsigned t = 0; t < 4; t++) begin
                case (t)
                    0:       set_target($urandom);
                    1:       set_target(VAL_MIN);
                    2:       set_target(VAL_MAX);
                    default: set_target($signed($urandom_range(20)) - 10);
                endcase
                if (mode == 1 && t == 0) begin
                    apb_write(ADDR_SPARE, $urandom);
                    verify_target();
                end
                phase_start = items_sent;
                set_no      = 0;
                while (items_sent - phase_start < PHASE_ITEMS) begin
                    if (t[0] && set_no == 1)
                        run_set($urandom_range(MAX_ITEMS - 4, MAX_ITEMS + 8), 1'b1);
                    else
                        run_set($urandom_range(1, 12), 1'b0);
                    set_no++;
                end
                settle();
            end
        end

        if (tracker.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/tsif_pkg.sv
hw/rtl/tsif_regs.sv
hw/rtl/tsif_ctrl.sv
hw/rtl/tsif_dp.sv
hw/rtl/two_sum_index_finder_core.sv
test/two_sum_index_finder_core_tb.sv
